@@ src/lqs_pkg.sv @@
package lqs_pkg;

  // Default geometry of the block.
  parameter int unsigned MaxItemsDef  = 32;
  parameter int unsigned DataWidthDef = 32;

  // Fixed width of the value fields on both channels.
  parameter int unsigned ValueW = 32;

  // Commands from the controller to the datapath. At most one is set per cycle.
  typedef struct packed {
    logic load;        // store the accepted element
    logic push_root;   // push the whole block as the first range
    logic pop;         // pop a range and read it from the stack
    logic take_range;  // latch lo/hi, start the scan, read the pivot entry
    logic take_pivot;  // latch the pivot, read the first scan entry
    logic step_skip;   // entry not below the pivot, advance the scan
    logic swap_rd;     // keep the scan entry, read the entry at the store index
    logic swap_wr_j;   // write the store-index entry to the scan index
    logic swap_wr_i;   // write the kept entry to the store index, advance both
    logic fin_rd;      // read the entry at the final pivot place
    logic fin_wr_hi;   // move that entry to the top of the range
    logic fin_wr_i;    // write the pivot into its final place
    logic push_a;      // push the first of the two sub-ranges
    logic push_b;      // push the second of the two sub-ranges
    logic out_start;   // start reading the sorted block
    logic out_load;    // move one sorted element to the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cnt_lt2;     // fewer than two elements are stored
    logic sp_zero;     // the range stack is empty
    logic scan_done;   // the scan has reached the pivot entry
    logic less;        // the scanned entry is below the pivot
    logic out_free;    // the output register can take an element
    logic out_final;   // the element being emitted is the final one
  } status_t;

endpackage

@@ src/lqs_in_if.sv @@
interface lqs_in_if;
  logic                              valid;
  logic                              ready;
  logic signed [lqs_pkg::ValueW-1:0] value;
  logic                              last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);
endinterface

@@ src/lqs_out_if.sv @@
interface lqs_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [lqs_pkg::ValueW-1:0] sorted_value;
  logic                              last_out;

  modport source (output valid, output sorted_value, output last_out, input ready);
  modport sink   (input valid, input sorted_value, input last_out, output ready);
endinterface

@@ src/lqs_datapath.sv @@
module lqs_datapath #(
  parameter int unsigned MAX_ITEMS  = lqs_pkg::MaxItemsDef,
  parameter int unsigned DATA_WIDTH = lqs_pkg::DataWidthDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lqs_pkg::cmd_t                     cmd_i,
  output lqs_pkg::status_t                  status_o,
  input  logic signed [lqs_pkg::ValueW-1:0] in_value_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [lqs_pkg::ValueW-1:0] out_value_o,
  output logic                              out_last_o
);

  localparam int unsigned IdxW = $clog2(MAX_ITEMS);
  localparam int unsigned CntW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned SeW  = 2 * IdxW;

  logic [DATA_WIDTH-1:0] elem_mem [MAX_ITEMS];
  logic [SeW-1:0]        stack_mem [MAX_ITEMS];

  logic [CntW-1:0]       cnt_q, sp_q;
  logic [IdxW-1:0]       lo_q, hi_q, i_q, j_q, k_q;
  logic [DATA_WIDTH-1:0] pivot_q, tmp_q, rdata_q;
  logic [SeW-1:0]        srdata_q;
  logic                  out_valid_q, out_last_q;
  logic [lqs_pkg::ValueW-1:0] out_value_q;

  logic [DATA_WIDTH-1:0] in_ext;
  logic                  not_full, stack_room;
  logic                  rd_en, wr_en, srd_en, swr_en;
  logic [IdxW-1:0]       rd_addr, wr_addr, srd_addr, swr_addr;
  logic [DATA_WIDTH-1:0] wr_data;
  logic [SeW-1:0]        swr_data;
  logic [IdxW-1:0]       s_lo, s_hi;
  logic [CntW-1:0]       sp_m1;
  logic [IdxW:0]         p_x, lo_x, hi_x;
  logic                  left_ok, right_ok, left_first;
  logic [SeW-1:0]        left_e, right_e;

  // Sign-extend or truncate the incoming value to the stored width.
  assign in_ext     = DATA_WIDTH'(in_value_i);
  assign not_full   = cnt_q < CntW'(MAX_ITEMS);
  assign stack_room = sp_q < CntW'(MAX_ITEMS);
  assign s_lo       = srdata_q[SeW-1:IdxW];
  assign s_hi       = srdata_q[IdxW-1:0];
  assign sp_m1      = sp_q - CntW'(1);

  // Sub-ranges left after the pivot lands at index i.
  assign p_x        = {1'b0, i_q};
  assign lo_x       = {1'b0, lo_q};
  assign hi_x       = {1'b0, hi_q};
  assign left_ok    = p_x > (lo_x + (IdxW + 1)'(1));
  assign right_ok   = (p_x + (IdxW + 1)'(1)) < hi_x;
  assign left_first = (p_x - lo_x) > (hi_x - p_x);
  assign left_e     = {lo_q, IdxW'(p_x - (IdxW + 1)'(1))};
  assign right_e    = {IdxW'(p_x + (IdxW + 1)'(1)), hi_q};

  assign status_o.cnt_lt2   = cnt_q < CntW'(2);
  assign status_o.sp_zero   = sp_q == '0;
  assign status_o.scan_done = j_q == hi_q;
  assign status_o.less      = $signed(rdata_q) < $signed(pivot_q);
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign status_o.out_final = CntW'(k_q) == (cnt_q - CntW'(1));

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = '0;
    wr_data = '0;
    if (cmd_i.take_range) begin
      rd_en   = 1'b1;
      rd_addr = s_hi;
    end
    if (cmd_i.take_pivot) begin
      rd_en   = 1'b1;
      rd_addr = j_q;
    end
    if (cmd_i.step_skip || cmd_i.swap_wr_i) begin
      rd_en   = 1'b1;
      rd_addr = j_q + IdxW'(1);
    end
    if (cmd_i.swap_rd || cmd_i.fin_rd) begin
      rd_en   = 1'b1;
      rd_addr = i_q;
    end
    if (cmd_i.out_start) begin
      rd_en   = 1'b1;
      rd_addr = '0;
    end
    if (cmd_i.out_load) begin
      rd_en   = 1'b1;
      rd_addr = k_q + IdxW'(1);
    end
    if (cmd_i.load && not_full) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q[IdxW-1:0];
      wr_data = in_ext;
    end
    if (cmd_i.swap_wr_j) begin
      wr_en   = 1'b1;
      wr_addr = j_q;
      wr_data = rdata_q;
    end
    if (cmd_i.swap_wr_i) begin
      wr_en   = 1'b1;
      wr_addr = i_q;
      wr_data = tmp_q;
    end
    if (cmd_i.fin_wr_hi) begin
      wr_en   = 1'b1;
      wr_addr = hi_q;
      wr_data = rdata_q;
    end
    if (cmd_i.fin_wr_i) begin
      wr_en   = 1'b1;
      wr_addr = i_q;
      wr_data = pivot_q;
    end
  end

  always_comb begin
    srd_en   = cmd_i.pop;
    srd_addr = sp_m1[IdxW-1:0];
    swr_en   = 1'b0;
    swr_addr = sp_q[IdxW-1:0];
    swr_data = '0;
    if (cmd_i.push_root) begin
      swr_en   = 1'b1;
      swr_addr = '0;
      swr_data = {IdxW'(0), IdxW'(cnt_q - CntW'(1))};
    end
    if (cmd_i.push_a) begin
      swr_en   = (left_first ? left_ok : right_ok) && stack_room;
      swr_data = left_first ? left_e : right_e;
    end
    if (cmd_i.push_b) begin
      swr_en   = (left_first ? right_ok : left_ok) && stack_room;
      swr_data = left_first ? right_e : left_e;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      elem_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= elem_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (swr_en) begin
      stack_mem[swr_addr] <= swr_data;
    end
    if (srd_en) begin
      srdata_q <= stack_mem[srd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      sp_q        <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      pivot_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load && not_full) begin
        cnt_q <= cnt_q + CntW'(1);
      end
      if (cmd_i.push_root) begin
        sp_q <= CntW'(1);
      end
      if (cmd_i.pop) begin
        sp_q <= sp_m1;
      end
      if (swr_en && !cmd_i.push_root) begin
        sp_q <= sp_q + CntW'(1);
      end
      if (cmd_i.take_range) begin
        lo_q <= s_lo;
        hi_q <= s_hi;
        i_q  <= s_lo;
        j_q  <= s_lo;
      end
      if (cmd_i.take_pivot) begin
        pivot_q <= rdata_q;
      end
      if (cmd_i.step_skip) begin
        j_q <= j_q + IdxW'(1);
      end
      if (cmd_i.swap_wr_i) begin
        i_q <= i_q + IdxW'(1);
        j_q <= j_q + IdxW'(1);
      end
      if (cmd_i.out_start) begin
        k_q <= '0;
      end
      if (cmd_i.out_load) begin
        k_q         <= k_q + IdxW'(1);
        out_valid_q <= 1'b1;
        if (status_o.out_final) begin
          cnt_q <= '0;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.swap_rd) begin
      tmp_q <= rdata_q;
    end
    if (cmd_i.out_load) begin
      out_value_q <= lqs_pkg::ValueW'(rdata_q);
      out_last_q  <= status_o.out_final;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_last_o  = out_last_q;

endmodule

@@ src/lqs_ctrl.sv @@
module lqs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_last_i,
  output logic             in_ready_o,
  input  lqs_pkg::status_t status_i,
  output lqs_pkg::cmd_t    cmd_o
);

  typedef enum logic [12:0] {
    S_LOAD  = 13'h0001,
    S_START = 13'h0002,
    S_POP   = 13'h0004,
    S_RANGE = 13'h0008,
    S_PIVOT = 13'h0010,
    S_SCAN  = 13'h0020,
    S_SW1   = 13'h0040,
    S_SW2   = 13'h0080,
    S_FIN1  = 13'h0100,
    S_FIN2  = 13'h0200,
    S_PUSHA = 13'h0400,
    S_PUSHB = 13'h0800,
    S_OUT   = 13'h1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == S_LOAD;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_LOAD: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        if (status_i.cnt_lt2) begin
          cmd_o.out_start = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.push_root = 1'b1;
          state_d         = S_POP;
        end
      end
      S_POP: begin
        if (status_i.sp_zero) begin
          cmd_o.out_start = 1'b1;
          state_d         = S_OUT;
        end else begin
          cmd_o.pop = 1'b1;
          state_d   = S_RANGE;
        end
      end
      S_RANGE: begin
        cmd_o.take_range = 1'b1;
        state_d          = S_PIVOT;
      end
      S_PIVOT: begin
        cmd_o.take_pivot = 1'b1;
        state_d          = S_SCAN;
      end
      S_SCAN: begin
        if (status_i.scan_done) begin
          cmd_o.fin_rd = 1'b1;
          state_d      = S_FIN1;
        end else if (status_i.less) begin
          cmd_o.swap_rd = 1'b1;
          state_d       = S_SW1;
        end else begin
          cmd_o.step_skip = 1'b1;
        end
      end
      S_SW1: begin
        cmd_o.swap_wr_j = 1'b1;
        state_d         = S_SW2;
      end
      S_SW2: begin
        cmd_o.swap_wr_i = 1'b1;
        state_d         = S_SCAN;
      end
      S_FIN1: begin
        cmd_o.fin_wr_hi = 1'b1;
        state_d         = S_FIN2;
      end
      S_FIN2: begin
        cmd_o.fin_wr_i = 1'b1;
        state_d        = S_PUSHA;
      end
      S_PUSHA: begin
        cmd_o.push_a = 1'b1;
        state_d      = S_PUSHB;
      end
      S_PUSHB: begin
        cmd_o.push_b = 1'b1;
        state_d      = S_POP;
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (status_i.out_final) begin
            state_d = S_LOAD;
          end
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ src/lomuto_quicksort_unit.sv @@
// Block sorter: elements arrive one per input transaction, one per cycle, and the one
// flagged last closes the block. Up to MAX_ITEMS elements are kept; further ones are
// dropped, but a dropped element that carries last still closes the block. The block
// is then sorted ascending as signed DATA_WIDTH-bit values by Lomuto-partition
// quicksort, and every kept element leaves in order on the output channel, one per
// cycle while the sink is ready, with last_out on the final one. Sorting runs on an
// element memory with one read port, one write port and registered read, so its time
// is set by the read port: each range is popped, its pivot read and its entries
// scanned, where an entry that is not below the pivot is skipped and one below it is
// swapped forward by a read, a write to the scan index and a write to the store
// index; the pivot then moves into its final place and the sub-ranges are pushed.
// Already ordered input is the slowest case. No input is taken from the closing
// element until the final sorted element has been moved to the output register; that
// register lets the next block load while the last result still waits to be taken.
module lomuto_quicksort_unit #(
  parameter int unsigned MAX_ITEMS  = lqs_pkg::MaxItemsDef,
  parameter int unsigned DATA_WIDTH = lqs_pkg::DataWidthDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  lqs_in_if.sink    in_i,
  lqs_out_if.source out_o
);

  lqs_pkg::cmd_t    cmd;
  lqs_pkg::status_t status;

  // The controller sequences loading, partitioning, the range stack and emission.
  lqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_last_i  (in_i.last),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the element store, the range stack, the scan indices,
  // the pivot and the output register.
  lqs_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_value_i  (in_i.value),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .out_value_o (out_o.sorted_value),
    .out_last_o  (out_o.last_out)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned ValueW      = lqs_pkg::ValueW;
  localparam int unsigned BlockCap    = lqs_pkg::MaxItemsDef;
  localparam int unsigned RandomItems = 480;
  localparam int unsigned LongHold    = 400;
  localparam int unsigned DrainCycles = 100;
  localparam int unsigned ReportMax   = 10;

  localparam logic signed [ValueW-1:0] ValueMin = {1'b1, {(ValueW-1){1'b0}}};
  localparam logic signed [ValueW-1:0] ValueMax = {1'b0, {(ValueW-1){1'b1}}};

  // Shapes of element content inside one block.
  typedef enum int unsigned {
    PAT_RANDOM,
    PAT_FEW_VALUES,
    PAT_ASCENDING,
    PAT_DESCENDING,
    PAT_EXTREMES
  } pattern_e;

  // Holds the elements of the block being loaded, sorts a closed block the way the
  // block does (Lomuto partition with an explicit range stack) and keeps the sorted
  // elements in order until they are seen on the output channel.
  class sort_scoreboard;
    logic signed [ValueW-1:0] open_block[$];
    logic signed [ValueW-1:0] sorted_values[$];
    logic                     sorted_finals[$];
    logic signed [ValueW-1:0] work[BlockCap];
    int unsigned              range_lo[BlockCap];
    int unsigned              range_hi[BlockCap];
    int unsigned              range_depth;
    int unsigned              mismatches;
    int unsigned              results_checked;
    int unsigned              blocks_closed;
    int unsigned              elements_taken;
    int unsigned              elements_dropped;

    function void push_range(int unsigned lo, int unsigned hi);
      if (lo < hi && range_depth < BlockCap) begin
        range_lo[range_depth] = lo;
        range_hi[range_depth] = hi;
        range_depth++;
      end
    endfunction

    function void swap_entries(int unsigned a, int unsigned b);
      logic signed [ValueW-1:0] held;
      held    = work[a];
      work[a] = work[b];
      work[b] = held;
    endfunction

    function void sort_work(int unsigned count);
      int unsigned              lo;
      int unsigned              hi;
      int unsigned              store_at;
      int unsigned              scan;
      logic signed [ValueW-1:0] pivot;
      range_depth = 0;
      if (count >= 2) push_range(0, count - 1);
      while (range_depth > 0) begin
        range_depth--;
        lo       = range_lo[range_depth];
        hi       = range_hi[range_depth];
        pivot    = work[hi];
        store_at = lo;
        for (scan = lo; scan < hi; scan++) begin
          if (work[scan] < pivot) begin
            swap_entries(store_at, scan);
            store_at++;
          end
        end
        swap_entries(store_at, hi);
        // The larger side goes on the stack first so the smaller one is done first.
        if (store_at - lo > hi - store_at) begin
          if (store_at > lo) push_range(lo, store_at - 1);
          push_range(store_at + 1, hi);
        end else begin
          push_range(store_at + 1, hi);
          if (store_at > lo) push_range(lo, store_at - 1);
        end
      end
    endfunction

    function void note_input(logic signed [ValueW-1:0] value, logic last_flag);
      int unsigned count;
      int unsigned k;
      elements_taken++;
      // Elements past the capacity are dropped, but their last flag still counts.
      if (open_block.size() < BlockCap) open_block = {open_block, value};
      else elements_dropped++;
      if (last_flag) begin
        count = open_block.size();
        for (k = 0; k < count; k++) work[k] = open_block[k];
        sort_work(count);
        for (k = 0; k < count; k++) begin
          sorted_values = {sorted_values, work[k]};
          sorted_finals = {sorted_finals, (k + 1 == count)};
        end
        open_block.delete();
        blocks_closed++;
      end
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= ReportMax) $display("%0t ns: %s", $time, msg);
    endfunction

    function void check_result(logic signed [ValueW-1:0] got_value, logic got_last);
      logic signed [ValueW-1:0] want_value;
      logic                     want_last;
      if (sorted_values.size() == 0) begin
        report($sformatf("unexpected result: sorted_value %0d last_out %b",
                         got_value, got_last));
        return;
      end
      want_value = sorted_values.pop_front();
      want_last  = sorted_finals.pop_front();
      results_checked++;
      if (got_value !== want_value)
        report($sformatf("sorted_value mismatch: expected %0d, got %0d",
                         want_value, got_value));
      if (got_last !== want_last)
        report($sformatf("last_out mismatch: expected %b, got %b (value %0d)",
                         want_last, got_last, want_value));
    endfunction

    function int unsigned pending();
      return sorted_values.size();
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  lqs_in_if  in_if ();
  lqs_out_if out_if ();

  lomuto_quicksort_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sort_scoreboard           board;
  logic signed [ValueW-1:0] block_vals[$];
  bit                       sender_eager;
  bit                       long_hold_due;
  int unsigned              random_sent;

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  initial begin : watchdog
    #2_000_000;
    $display("lomuto_quicksort_unit regression: fail");
    $finish;
  end

  // Offers one element, after a random gap, and holds it until the block takes it.
  task automatic send_element(input logic signed [ValueW-1:0] value, input logic last_flag);
    int unsigned gap;
    if ($urandom_range(0, 15) == 0) sender_eager = !sender_eager;
    gap = sender_eager ? 0 : $urandom_range(0, 10);
    @(negedge clk_i);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.value <= value;
    in_if.last  <= last_flag;
    do @(posedge clk_i); while (!in_if.ready);
    board.note_input(value, last_flag);
  endtask

  // Sends the elements in block_vals, the final one flagged last.
  task automatic send_block();
    int unsigned k;
    for (k = 0; k < block_vals.size(); k++)
      send_element(block_vals[k], k + 1 == block_vals.size());
    block_vals.delete();
  endtask

  function automatic logic signed [ValueW-1:0] pick_value(
    pattern_e pat, int unsigned idx, logic signed [ValueW-1:0] base,
    logic signed [ValueW-1:0] stride);
    logic signed [ValueW-1:0] v;
    case (pat)
      PAT_FEW_VALUES: begin
        case ($urandom_range(0, 4))
          0:       v = ValueMin;
          1:       v = -1;
          2:       v = 0;
          3:       v = 1;
          default: v = ValueMax;
        endcase
      end
      PAT_ASCENDING:  v = base + idx * stride;
      PAT_DESCENDING: v = base - idx * stride;
      PAT_EXTREMES: begin
        if ($urandom_range(0, 1) == 1) v = ValueMin + $urandom_range(0, 3);
        else v = ValueMax - $urandom_range(0, 3);
      end
      default:        v = $urandom;
    endcase
    return v;
  endfunction

  // Result side: random stalls, one long hold-off on request, and a check of every
  // result transaction at the clock edge where it is accepted.
  initial begin : result_sink
    int unsigned stall;
    bit          eager;
    eager = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 15) == 0) eager = !eager;
      stall = eager ? 0 : $urandom_range(0, 10);
      if (long_hold_due) begin
        stall         = LongHold;
        long_hold_due = 1'b0;
      end
      @(negedge clk_i);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      board.check_result(out_if.sorted_value, out_if.last_out);
    end
  end

  initial begin : stimulus
    int unsigned len;
    int unsigned roll;
    int unsigned k;
    bit          hold_done;
    pattern_e    pat;
    logic signed [ValueW-1:0] base;
    logic signed [ValueW-1:0] stride;

    board         = new();
    sender_eager  = 1'b0;
    long_hold_due = 1'b0;
    hold_done     = 1'b0;
    random_sent   = 0;
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.value   = '0;
    in_if.last    = 1'b0;
    out_if.ready  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed blocks: single elements at both extremes, extremes together,
    // duplicates, already ordered, reverse ordered and all-equal content.
    block_vals = '{ValueMin};
    send_block();
    block_vals = '{ValueMax};
    send_block();
    block_vals = '{ValueMax, ValueMin};
    send_block();
    block_vals = '{0, -1, 1, ValueMin, ValueMax, 0};
    send_block();
    block_vals = '{-2, -1, 0, 1, 2};
    send_block();
    block_vals = '{3, 2, 1, 0, -7};
    send_block();
    block_vals = '{5, 5, 5};
    send_block();

    // Random blocks: mostly short, some at full capacity, a few that overflow it.
    while (random_sent < RandomItems) begin
      roll = $urandom_range(0, 99);
      if (roll < 6) len = $urandom_range(BlockCap + 1, BlockCap + 8);
      else if (roll < 12) len = BlockCap;
      else if (roll < 30) len = $urandom_range(13, BlockCap - 1);
      else len = $urandom_range(1, 12);
      pat    = pattern_e'($urandom_range(PAT_RANDOM, PAT_EXTREMES));
      base   = $urandom;
      stride = $urandom_range(0, 1000);
      for (k = 0; k < len; k++) block_vals = {block_vals, pick_value(pat, k, base, stride)};

      // Halfway through, the result side stops for a long stretch while the
      // input side keeps offering eagerly, so the block fills and stalls.
      if (!hold_done && random_sent >= RandomItems / 2) begin
        hold_done     = 1'b1;
        long_hold_due = 1'b1;
        sender_eager  = 1'b1;
      end
      random_sent += (len > BlockCap) ? BlockCap : len;
      send_block();
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sorted %0d blocks from %0d input transactions (%0d past capacity),",
             board.blocks_closed, board.elements_taken, board.elements_dropped);
    $display("checked %0d ordered results, with one %0d-cycle output hold-off.",
             board.results_checked, LongHold);
    if (board.mismatches == 0) begin
      $display("lomuto_quicksort_unit regression: pass");
    end else begin
      $display("%0d mismatches in total.", board.mismatches);
      $display("lomuto_quicksort_unit regression: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
src/lqs_pkg.sv
src/lqs_in_if.sv
src/lqs_out_if.sv
src/lqs_datapath.sv
src/lqs_ctrl.sv
src/lomuto_quicksort_unit.sv
dv/testbench.sv
